// ===== sv/ltm_pkg.sv =====
// ltm_pkg: constants and key helpers for the loser tree run merge
// used by loser_tree_run_merge; no dependencies
package ltm_pkg;

    localparam int DEPTH_W          = 32;
    localparam int INDEX_W          = 12;
    localparam int KEY_W            = 34;
    localparam int MAX_ELEMENTS_DEF = 4096;
    localparam int MAX_RUNS_DEF     = 64;

    localparam logic [KEY_W-1:0] KEY_MINMARK   = '0;
    localparam logic [KEY_W-1:0] KEY_EXHAUSTED = {2'b10, 32'h0000_0000};
    localparam logic [31:0]      SIGN_MASK     = 32'h8000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // order preserving float key plus one, live heads never reach the build marker
    function automatic logic [KEY_W-1:0] ext_key(input logic [DEPTH_W-1:0] bits);
        logic [DEPTH_W-1:0] flipped;
        flipped = bits[DEPTH_W-1] ? ~bits : (bits ^ SIGN_MASK);
        return {2'b00, flipped} + {{(KEY_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

// ===== sv/loser_tree_run_merge.sv =====
// loser_tree_run_merge: k-way merge of ascending runs through a loser tree
// depends on ltm_pkg and ltm_ram
//
// a load beat is taken in S_IDLE; a pull in load order reads its element in S_NB and stages it
// in merge mode a pull steps through S_MA, S_MB, S_MC and S_MD and, unless the replay is skipped,
// through S_WR and S_WC per tree level replayed (log2 of the run count, rounded up, levels at
// most) and S_WEND; the next beat is taken once the result has moved into the output register
// the first pull of a batch passes through S_FIN to close the trailing run and, when merging,
// runs a tree build that clears the nodes in S_CLR, then inserts each run through S_BA to S_WEND
// the tree walk does one read-compare-write of the node memory per level
// reset is asynchronous active low; counts, phase and flags clear, merge_enable resets to 1
module loser_tree_run_merge
    import ltm_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
    parameter int MAX_RUNS     = MAX_RUNS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: merge_enable
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // depth_bits[31:0], source_index[43:32], zero fill
    input  logic        s_tlast,   // run_last
    input  logic        s_tuser,   // cmd
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_index[11:0], out_depth_bits[43:12], zero fill
    output logic        m_tlast,   // out_last
    output logic [1:0]  m_tuser    // out_empty[0], out_overflow[1]
);

    localparam int EW   = $clog2(MAX_ELEMENTS + 1);  // element counts
    localparam int EAW  = $clog2(MAX_ELEMENTS);      // element address
    localparam int RCW  = $clog2(MAX_RUNS + 1);      // run counts
    localparam int RAW  = $clog2(MAX_RUNS);          // run address
    localparam int RW   = $clog2(MAX_RUNS + 2);      // run tag, all ones above any run
    localparam int ELW  = DEPTH_W + INDEX_W;
    localparam int NW   = RW + KEY_W;

    localparam logic [EW-1:0]  MAX_E_C = EW'(MAX_ELEMENTS);
    localparam logic [RCW-1:0] MAX_R_C = RCW'(MAX_RUNS);
    localparam logic [RW-1:0]  RUN_TOP = '1;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_FIN  = 14'b00000000000010,
        S_CLR  = 14'b00000000000100,
        S_BA   = 14'b00000000001000,
        S_BB   = 14'b00000000010000,
        S_BC   = 14'b00000000100000,
        S_WR   = 14'b00000001000000,
        S_WC   = 14'b00000010000000,
        S_WEND = 14'b00000100000000,
        S_MA   = 14'b00001000000000,
        S_MB   = 14'b00010000000000,
        S_MC   = 14'b00100000000000,
        S_MD   = 14'b01000000000000,
        S_NB   = 14'b10000000000000
    } state_t;

    // a finished result waits in pend until the output register frees
    state_t            state_reg, state_next;
    logic [EW-1:0]     elem_cnt_reg, elem_cnt_next;
    logic [RCW-1:0]    run_cnt_reg, run_cnt_next;
    logic [EW-1:0]     emit_cnt_reg, emit_cnt_next;
    logic [EW-1:0]     last_end_reg, last_end_next;
    logic              merging_reg, merging_next;
    logic              ovf_reg, ovf_next;
    logic              mode_reg, mode_next;
    logic              en_reg, en_next;
    logic [RCW-1:0]    i_reg, i_next;
    logic [RCW-1:0]    p_reg, p_next;
    logic              build_reg, build_next;
    logic [KEY_W-1:0]  cur_key_reg, cur_key_next;
    logic [RW-1:0]     cur_run_reg, cur_run_next;
    logic [KEY_W-1:0]  lo_key_reg, lo_key_next;
    logic [RW-1:0]     lo_run_reg, lo_run_next;
    logic [KEY_W-1:0]  ru_key_reg, ru_key_next;
    logic [RW-1:0]     ru_run_reg, ru_run_next;
    logic [RW-1:0]     top_run_reg, top_run_next;
    logic [RAW-1:0]    w_reg, w_next;
    logic [EW-1:0]     pos_reg, pos_next;
    logic [EW-1:0]     end_reg, end_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic [DEPTH_W-1:0] res_depth_reg, res_depth_next;
    logic              pend_reg, pend_next;      // result staged, waiting for output slot
    logic              pend_empty_reg, pend_empty_next;
    logic              mv_reg, mv_next;
    logic [47:0]       md_reg, md_next;
    logic              ml_reg, ml_next;
    logic [1:0]        mu_reg, mu_next;

    // memory ports
    logic              el_we;
    logic [EAW-1:0]    el_waddr, el_raddr;
    logic [ELW-1:0]    el_wdata, el_rdata;
    logic              re_we;
    logic [RAW-1:0]    re_waddr, re_raddr;
    logic [EW-1:0]     re_wdata, re_rdata;
    logic              rp_we;
    logic [RAW-1:0]    rp_waddr, rp_raddr;
    logic [EW-1:0]     rp_wdata, rp_rdata;
    logic              nd_we;
    logic [RAW-1:0]    nd_waddr, nd_raddr;
    logic [NW-1:0]     nd_wdata, nd_rdata;

    ltm_ram #(.WIDTH(ELW), .DEPTH(MAX_ELEMENTS)) u_elem (
        .clk(clk), .we(el_we), .waddr(el_waddr), .wdata(el_wdata),
        .raddr(el_raddr), .rdata(el_rdata)
    );
    ltm_ram #(.WIDTH(EW), .DEPTH(MAX_RUNS)) u_run_end (
        .clk(clk), .we(re_we), .waddr(re_waddr), .wdata(re_wdata),
        .raddr(re_raddr), .rdata(re_rdata)
    );
    ltm_ram #(.WIDTH(EW), .DEPTH(MAX_RUNS)) u_run_pos (
        .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
        .raddr(rp_raddr), .rdata(rp_rdata)
    );
    ltm_ram #(.WIDTH(NW), .DEPTH(MAX_RUNS)) u_nodes (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata)
    );

    // key order with ties broken by run number
    function automatic logic above(input logic [KEY_W-1:0] ak, input logic [RW-1:0] ar,
                                   input logic [KEY_W-1:0] bk, input logic [RW-1:0] br);
        return (ak > bk) || ((ak == bk) && (ar > br));
    endfunction

    function automatic logic [EAW-1:0] slot(input logic [EW-1:0] pos);
        return (pos < MAX_E_C) ? pos[EAW-1:0] : '0;
    endfunction

    logic              in_acc;
    logic              out_free;
    logic [KEY_W-1:0]  nd_key;
    logic [RW-1:0]     nd_run;
    logic [RCW:0]      path_sum;
    logic [RAW-1:0]    w_c;
    logic [KEY_W-1:0]  nh_key;
    logic [EW-1:0]     emit_inc;

    assign s_tready = (state_reg == S_IDLE) && !pend_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign nd_key   = nd_rdata[KEY_W-1:0];
    assign nd_run   = nd_rdata[NW-1:KEY_W];
    assign emit_inc = emit_cnt_reg + EW'(1);

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    always_comb
    begin
        state_next      = state_reg;
        elem_cnt_next   = elem_cnt_reg;
        run_cnt_next    = run_cnt_reg;
        emit_cnt_next   = emit_cnt_reg;
        last_end_next   = last_end_reg;
        merging_next    = merging_reg;
        ovf_next        = ovf_reg;
        mode_next       = mode_reg;
        en_next         = cfg_wen ? cfg_wdata : en_reg;
        i_next          = i_reg;
        p_next          = p_reg;
        build_next      = build_reg;
        cur_key_next    = cur_key_reg;
        cur_run_next    = cur_run_reg;
        lo_key_next     = lo_key_reg;
        lo_run_next     = lo_run_reg;
        ru_key_next     = ru_key_reg;
        ru_run_next     = ru_run_reg;
        top_run_next    = top_run_reg;
        w_next          = w_reg;
        pos_next        = pos_reg;
        end_next        = end_reg;
        res_index_next  = res_index_reg;
        res_depth_next  = res_depth_reg;
        pend_next       = pend_reg;
        pend_empty_next = pend_empty_reg;
        mv_next         = (mv_reg && !m_tready) ? 1'b1 : 1'b0;
        md_next         = md_reg;
        ml_next         = ml_reg;
        mu_next         = mu_reg;

        el_we    = 1'b0;
        el_waddr = elem_cnt_reg[EAW-1:0];
        el_wdata = {s_tdata[43:32], s_tdata[31:0]};
        el_raddr = '0;
        re_we    = 1'b0;
        re_waddr = run_cnt_reg[RAW-1:0];
        re_wdata = elem_cnt_reg + EW'(1);
        re_raddr = '0;
        rp_we    = 1'b0;
        rp_waddr = i_reg[RAW-1:0];
        rp_wdata = '0;
        rp_raddr = '0;
        nd_we    = 1'b0;
        nd_waddr = p_reg[RAW-1:0];
        nd_wdata = {cur_run_reg, cur_key_reg};
        nd_raddr = p_reg[RAW-1:0];

        path_sum = '0;
        w_c      = (top_run_reg >= RW'(run_cnt_reg)) ? '0 : top_run_reg[RAW-1:0];
        nh_key   = (pos_reg < end_reg) ? ext_key(el_rdata[DEPTH_W-1:0]) : KEY_EXHAUSTED;

        // staged result moves to the output register when it is free
        if (pend_reg && out_free)
        begin
            pend_next = 1'b0;
            mv_next   = 1'b1;
            if (pend_empty_reg)
            begin
                md_next = '0;
                ml_next = 1'b0;
                mu_next = 2'b01;
            end
            else
            begin
                md_next = {4'b0000, res_depth_reg, res_index_reg};
                ml_next = (emit_inc >= elem_cnt_reg);
                mu_next = {ovf_reg, 1'b0};
                emit_cnt_next = emit_inc;
                if (emit_inc >= elem_cnt_reg)
                begin
                    // end of batch
                    elem_cnt_next = '0;
                    run_cnt_next  = '0;
                    emit_cnt_next = '0;
                    last_end_next = '0;
                    merging_next  = 1'b0;
                    ovf_next      = 1'b0;
                    mode_next     = 1'b0;
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == CMD_LOAD)
                    begin
                        if (!merging_reg)
                        begin
                            if (elem_cnt_reg >= MAX_E_C || run_cnt_reg >= MAX_R_C)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                el_we         = 1'b1;
                                elem_cnt_next = elem_cnt_reg + EW'(1);
                                if (s_tlast)
                                begin
                                    re_we         = 1'b1;
                                    run_cnt_next  = run_cnt_reg + RCW'(1);
                                    last_end_next = elem_cnt_reg + EW'(1);
                                end
                            end
                        end
                    end
                    else if (!merging_reg)
                    begin
                        if (elem_cnt_reg == '0)
                        begin
                            pend_next       = 1'b1;
                            pend_empty_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else if (mode_reg)
                    begin
                        state_next = S_MA;
                    end
                    else
                    begin
                        el_raddr   = slot(emit_cnt_reg);
                        state_next = S_NB;
                    end
                end
            end
            S_FIN:
            begin
                // open trailing run closes here
                run_cnt_next = run_cnt_reg;
                if (elem_cnt_reg > last_end_reg && run_cnt_reg < MAX_R_C)
                begin
                    re_we        = 1'b1;
                    re_wdata     = elem_cnt_reg;
                    run_cnt_next = run_cnt_reg + RCW'(1);
                end
                mode_next    = en_reg && (run_cnt_next > RCW'(1));
                merging_next = 1'b1;
                i_next       = '0;
                if (en_reg && (run_cnt_next > RCW'(1)))
                begin
                    state_next = S_CLR;
                end
                else
                begin
                    el_raddr   = slot(emit_cnt_reg);
                    state_next = S_NB;
                end
            end
            S_CLR:
            begin
                nd_we    = 1'b1;
                nd_waddr = i_reg[RAW-1:0];
                nd_wdata = {RW'(run_cnt_reg), KEY_MINMARK};
                if (i_reg == run_cnt_reg - RCW'(1))
                begin
                    state_next = S_BA;
                end
                else
                begin
                    i_next = i_reg + RCW'(1);
                end
            end
            S_BA:
            begin
                re_raddr   = RAW'(i_reg - RCW'(1));
                state_next = S_BB;
            end
            S_BB:
            begin
                rp_we        = 1'b1;
                rp_waddr     = i_reg[RAW-1:0];
                rp_wdata     = (i_reg == '0) ? '0 : re_rdata;
                el_raddr     = slot((i_reg == '0) ? '0 : re_rdata);
                cur_run_next = RW'(i_reg);
                path_sum     = {1'b0, run_cnt_reg} + {1'b0, i_reg};
                p_next       = path_sum[RCW:1];
                build_next   = 1'b1;
                state_next   = S_BC;
            end
            S_BC:
            begin
                cur_key_next = ext_key(el_rdata[DEPTH_W-1:0]);
                state_next   = (p_reg == '0) ? S_WEND : S_WR;
            end
            S_WR:
            begin
                state_next = S_WC;
            end
            S_WC:
            begin
                if (above(cur_key_reg, cur_run_reg, nd_key, nd_run))
                begin
                    nd_we        = 1'b1;
                    cur_key_next = nd_key;
                    cur_run_next = nd_run;
                end
                else if (!build_reg && above(lo_key_reg, lo_run_reg, nd_key, nd_run))
                begin
                    lo_key_next = nd_key;
                    lo_run_next = nd_run;
                end
                p_next     = p_reg >> 1;
                state_next = ((p_reg >> 1) == '0) ? S_WEND : S_WR;
            end
            S_WEND:
            begin
                top_run_next = cur_run_reg;
                if (build_reg)
                begin
                    if (i_reg == '0)
                    begin
                        ru_key_next = KEY_MINMARK;
                        ru_run_next = '0;
                        state_next  = S_MA;
                    end
                    else
                    begin
                        i_next     = i_reg - RCW'(1);
                        state_next = S_BA;
                    end
                end
                else
                begin
                    if (cur_run_reg == RW'(w_reg))
                    begin
                        ru_key_next = lo_key_reg;
                        ru_run_next = lo_run_reg;
                    end
                    else
                    begin
                        ru_key_next = KEY_MINMARK;
                        ru_run_next = '0;
                    end
                    pend_next       = 1'b1;
                    pend_empty_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_MA:
            begin
                w_next     = w_c;
                rp_raddr   = w_c;
                re_raddr   = w_c;
                state_next = S_MB;
            end
            S_MB:
            begin
                pos_next   = rp_rdata + EW'(1);
                end_next   = re_rdata;
                rp_we      = 1'b1;
                rp_waddr   = w_reg;
                rp_wdata   = rp_rdata + EW'(1);
                el_raddr   = slot(rp_rdata);
                state_next = S_MC;
            end
            S_MC:
            begin
                res_index_next = el_rdata[ELW-1:DEPTH_W];
                res_depth_next = el_rdata[DEPTH_W-1:0];
                el_raddr       = slot(pos_reg);
                state_next     = S_MD;
            end
            S_MD:
            begin
                cur_key_next = nh_key;
                cur_run_next = RW'(w_reg);
                lo_key_next  = KEY_EXHAUSTED;
                lo_run_next  = RUN_TOP;
                build_next   = 1'b0;
                path_sum     = {1'b0, run_cnt_reg} + {1'b0, RCW'(w_reg)};
                p_next       = path_sum[RCW:1];
                if (above(ru_key_reg, ru_run_reg, nh_key, RW'(w_reg)))
                begin
                    // head still below runner-up, tree unchanged
                    pend_next       = 1'b1;
                    pend_empty_next = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = (path_sum[RCW:1] == '0) ? S_WEND : S_WR;
                end
            end
            S_NB:
            begin
                res_index_next  = el_rdata[ELW-1:DEPTH_W];
                res_depth_next  = el_rdata[DEPTH_W-1:0];
                pend_next       = 1'b1;
                pend_empty_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            elem_cnt_reg <= '0;
            run_cnt_reg  <= '0;
            emit_cnt_reg <= '0;
            last_end_reg <= '0;
            merging_reg  <= 1'b0;
            ovf_reg      <= 1'b0;
            mode_reg     <= 1'b0;
            en_reg       <= 1'b1;
            pend_reg     <= 1'b0;
            mv_reg       <= 1'b0;
            ru_key_reg   <= KEY_MINMARK;
            ru_run_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            run_cnt_reg  <= run_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            last_end_reg <= last_end_next;
            merging_reg  <= merging_next;
            ovf_reg      <= ovf_next;
            mode_reg     <= mode_next;
            en_reg       <= en_next;
            pend_reg     <= pend_next;
            mv_reg       <= mv_next;
            ru_key_reg   <= ru_key_next;
            ru_run_reg   <= ru_run_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        p_reg          <= p_next;
        build_reg      <= build_next;
        cur_key_reg    <= cur_key_next;
        cur_run_reg    <= cur_run_next;
        lo_key_reg     <= lo_key_next;
        lo_run_reg     <= lo_run_next;
        top_run_reg    <= top_run_next;
        w_reg          <= w_next;
        pos_reg        <= pos_next;
        end_reg        <= end_next;
        res_index_reg  <= res_index_next;
        res_depth_reg  <= res_depth_next;
        pend_empty_reg <= pend_empty_next;
        md_reg         <= md_next;
        ml_reg         <= ml_next;
        mu_reg         <= mu_next;
    end

endmodule

// ===== sv/ltm_ram.sv =====
// ltm_ram: generic simple dual port ram with registered read
// no dependencies
module ltm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== verif/testbench.sv =====
// testbench for loser_tree_run_merge: load and pull beats against a behavioral merge predictor
// depends on ltm_pkg and the loser_tree_run_merge rtl
`timescale 1ns / 1ps

module testbench;
    import ltm_pkg::*;

    localparam int MAX_E      = MAX_ELEMENTS_DEF;
    localparam int MAX_R      = MAX_RUNS_DEF;
    localparam int CYCLE_CAP  = 2_000_000;
    localparam int RAND_ITEMS = 470;

    typedef logic [KEY_W-1:0] key_t;

    typedef struct {
        logic        cmd;
        logic [31:0] depth;
        logic [11:0] index;
        logic        run_end;
    } beat_t;

    typedef struct {
        logic [11:0] index;
        logic [31:0] depth;
        logic        last;
        logic        empty;
        logic        ovf;
    } merged_t;

    typedef struct {
        int unsigned run;
        key_t        key;
    } node_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;      // depth_bits[31:0], source_index[43:32], zero fill
    logic        s_tlast = 1'b0;    // run_last
    logic        s_tuser = 1'b0;    // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // out_index[11:0], out_depth_bits[43:12], zero fill
    logic        m_tlast;           // out_last
    logic [1:0]  m_tuser;           // out_empty[0], out_overflow[1]

    loser_tree_run_merge uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    beat_t   beat_q[$];         // beats waiting for the driver
    merged_t merged_q[$];       // merged elements still owed by the block
    int      errors = 0;
    int      n_items = 0;
    int      cycles = 0;
    int      send_gap = 0;
    int      recv_gap = 0;
    bit      calm = 1'b0;       // no idling in the closing stretch

    // ---------------------------------------------------------------
    // merge predictor: its own copy of the stores and the loser tree
    // ---------------------------------------------------------------
    logic [31:0] depth_mem[MAX_E];
    logic [11:0] index_mem[MAX_E];
    int unsigned run_end_at[MAX_R];
    int unsigned run_head[MAX_R];
    node_t       loser[MAX_R];
    node_t       runner_up;
    int unsigned elems;
    int unsigned runs;
    int unsigned emitted;
    bit          pulling;
    bit          ovf_seen;
    bit          by_depth;          // merge mode latched at the first pull
    bit          merge_en = 1'b1;

    // sign-flip ordering key, offset by one so the build marker sits below every live head
    function automatic key_t order_key(logic [31:0] d);
        logic [31:0] f;
        f = d[31] ? ~d : {1'b1, d[30:0]};
        return {2'b00, f} + key_t'(1);
    endfunction

    // strict ordering, the higher run loses a tie
    function automatic bit loses_to(node_t a, node_t b);
        return (a.key > b.key) || (a.key == b.key && a.run > b.run);
    endfunction

    function automatic void clear_batch();
        elems    = 0;
        runs     = 0;
        emitted  = 0;
        pulling  = 1'b0;
        ovf_seen = 1'b0;
        by_depth = 1'b0;
    endfunction

    function automatic void open_batch();
        int unsigned prev_end;
        int unsigned k;
        node_t       cur;
        node_t       t;
        prev_end = runs ? run_end_at[runs-1] : 0;
        // elements after the last run end close one more run
        if (elems > prev_end && runs < MAX_R)
        begin
            run_end_at[runs] = elems;
            runs++;
        end
        by_depth = merge_en && runs > 1;
        pulling  = 1'b1;
        if (!by_depth)
            return;
        k = runs;
        for (int unsigned i = 0; i < k; i++)
        begin
            run_head[i] = i ? run_end_at[i-1] : 0;
            loser[i].run = k;
            loser[i].key = KEY_MINMARK;
        end
        for (int i = int'(k) - 1; i >= 0; i--)
        begin
            cur.run = i;
            cur.key = order_key(depth_mem[run_head[i]]);
            for (int unsigned p = (k + i) / 2; p > 0; p /= 2)
            begin
                if (loses_to(cur, loser[p]))
                begin
                    t = loser[p];
                    loser[p] = cur;
                    cur = t;
                end
            end
            loser[0] = cur;
        end
        runner_up.run = 0;
        runner_up.key = KEY_MINMARK;
    endfunction

    // pops the tree winner and replays its path unless it still beats the runner-up
    function automatic int unsigned pop_winner();
        int unsigned k;
        int unsigned w;
        int unsigned pos;
        int unsigned slot;
        node_t       nh;
        node_t       cur;
        node_t       lo;
        node_t       t;
        k = runs;
        w = loser[0].run;
        if (w >= k)
            w = 0;
        pos  = run_head[w];
        slot = pos;
        pos++;
        nh.run = w;
        nh.key = (pos < run_end_at[w]) ? order_key(depth_mem[pos]) : KEY_EXHAUSTED;
        run_head[w] = pos;
        if (loses_to(runner_up, nh))
            return slot;
        cur    = nh;
        lo.run = 32'hFFFF_FFFF;
        lo.key = KEY_EXHAUSTED;
        for (int unsigned p = (k + w) / 2; p > 0; p /= 2)
        begin
            if (loses_to(cur, loser[p]))
            begin
                t = loser[p];
                loser[p] = cur;
                cur = t;
            end
            else if (loses_to(lo, loser[p]))
                lo = loser[p];
        end
        loser[0] = cur;
        if (cur.run == w)
            runner_up = lo;
        else
        begin
            runner_up.run = 0;
            runner_up.key = KEY_MINMARK;
        end
        return slot;
    endfunction

    // returns 1 when the beat yields a merged element
    function automatic bit predict_beat(beat_t b, output merged_t r);
        int unsigned slot;
        r = '{default: '0};
        if (b.cmd == CMD_LOAD)
        begin
            if (pulling)
                return 1'b0;
            if (elems >= MAX_E || runs >= MAX_R)
            begin
                ovf_seen = 1'b1;
                return 1'b0;
            end
            depth_mem[elems] = b.depth;
            index_mem[elems] = b.index;
            elems++;
            if (b.run_end)
            begin
                run_end_at[runs] = elems;
                runs++;
            end
            return 1'b0;
        end
        if (!pulling)
        begin
            if (elems == 0)
            begin
                r.empty = 1'b1;
                return 1'b1;
            end
            open_batch();
        end
        slot    = by_depth ? pop_winner() : emitted;
        r.index = index_mem[slot];
        r.depth = depth_mem[slot];
        r.ovf   = ovf_seen;
        emitted++;
        if (emitted >= elems)
        begin
            r.last = 1'b1;
            clear_batch();
        end
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // driver: presents queued beats, keeps a beat up until it is taken
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        merged_t r;
        bit      go;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (predict_beat(beat_q[0], r))
                    merged_q.push_back(r);
                void'(beat_q.pop_front());
            end
            go = 1'b0;
            if (s_tvalid && !s_tready)
                go = 1'b1;          // stream rule: a beat may not be withdrawn
            else if (send_gap > 0)
                send_gap--;
            else if (!calm && $urandom_range(0, 15) == 0)
                send_gap = $urandom_range(1, 17);
            else if (beat_q.size() > 0)
                go = 1'b1;
            s_tvalid <= go;
            if (go)
            begin
                s_tdata <= {4'b0000, beat_q[0].index, beat_q[0].depth};
                s_tlast <= beat_q[0].run_end;
                s_tuser <= beat_q[0].cmd;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: random backpressure, each result beat checked against the oldest expectation
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        merged_t e;
        bit      rdy;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (merged_q.size() == 0)
                    report_mismatch("result beat with nothing expected", m_tdata[31:0], 0);
                else
                begin
                    e = merged_q.pop_front();
                    if (m_tdata[11:0] !== e.index)
                        report_mismatch("out_index", m_tdata[11:0], e.index);
                    if (m_tdata[43:12] !== e.depth)
                        report_mismatch("out_depth_bits", m_tdata[43:12], e.depth);
                    if (m_tdata[47:44] !== 4'b0000)
                        report_mismatch("tdata fill", m_tdata[47:44], 0);
                    if (m_tlast !== e.last)
                        report_mismatch("out_last", m_tlast, e.last);
                    if (m_tuser[0] !== e.empty)
                        report_mismatch("out_empty", m_tuser[0], e.empty);
                    if (m_tuser[1] !== e.ovf)
                        report_mismatch("out_overflow", m_tuser[1], e.ovf);
                end
            end
            rdy = 1'b0;
            if (recv_gap > 0)
                recv_gap--;
            else if (!calm && $urandom_range(0, 15) == 0)
                recv_gap = $urandom_range(1, 17);
            else
                rdy = 1'b1;
            m_tready <= rdy;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    task automatic push_load(logic [31:0] d, logic [11:0] idx, logic last);
        beat_q.push_back('{cmd: CMD_LOAD, depth: d, index: idx, run_end: last});
        n_items++;
    endtask

    task automatic push_pull();
        beat_q.push_back('{cmd: CMD_PULL, depth: $urandom, index: 12'($urandom),
                           run_end: 1'($urandom)});
        n_items++;
    endtask

    // drain every beat and result, let the block settle, then write merge_enable
    task automatic write_merge_enable(logic v);
        while (beat_q.size() > 0 || merged_q.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        merge_en   = v;
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // one batch of loads then enough pulls to drain it; runs ascend unless scrambled
    task automatic gen_batch(int n, int end_pct, bit sorted, bit noise);
        int          stored;
        int          closed;
        logic [32:0] fk;
        logic [31:0] f;
        logic [31:0] d;
        logic        last;
        stored = 0;
        closed = 0;
        fk = 33'($urandom_range(0, 32'hE000_0000));
        for (int i = 0; i < n; i++)
        begin
            if (sorted)
            begin
                f = fk[32] ? 32'hFFFF_FFFF : fk[31:0];
                d = f[31] ? (f ^ SIGN_MASK) : ~f;   // back from flipped order to float bits
                if ($urandom_range(0, 5) != 0)
                    fk = fk + 33'($urandom_range(0, 1 << $urandom_range(0, 27)));
            end
            else
                d = $urandom;
            last = ($urandom_range(0, 99) < end_pct);
            push_load(d, 12'($urandom), last);
            if (stored < MAX_E && closed < MAX_R)
            begin
                stored++;
                if (last)
                    closed++;
            end
            if (last)
                fk = 33'($urandom_range(0, 32'hE000_0000));
        end
        if (stored == 0)
            push_pull();
        for (int j = 0; j < stored; j++)
        begin
            // a load while pulling is ignored by the block
            if (noise && j > 0 && $urandom_range(0, 7) == 0)
                push_load($urandom, 12'($urandom), 1'($urandom));
            push_pull();
        end
        if ($urandom_range(0, 9) == 0)
            push_pull();            // one past the end reads as empty
    endtask

    initial
    begin
        int rand_start;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pull, float extremes, ties across runs, open trailing run
        push_pull();
        push_load(32'hFF7F_FFFF, 12'h000, 1'b0);   // -max float
        push_load(32'h8000_0000, 12'hFFF, 1'b1);   // negative zero
        push_load(32'h0000_0000, 12'h001, 1'b0);
        push_load(32'h7F7F_FFFF, 12'h002, 1'b1);   // +max float
        push_load(32'h8000_0000, 12'h003, 1'b0);   // ties with the first run
        push_load(32'h7F80_0000, 12'h004, 1'b1);   // +inf
        push_load(32'hFFFF_FFFF, 12'h005, 1'b0);   // nan, sorts below everything
        push_load(32'h7F7F_FFFF, 12'h006, 1'b0);   // trailing run left open
        push_pull();
        push_load(32'h1234_5678, 12'hABC, 1'b1);   // ignored while pulling
        repeat (7) push_pull();
        push_pull();

        // load order with merging off
        write_merge_enable(1'b0);
        gen_batch(6, 30, 1'b1, 1'b1);
        write_merge_enable(1'b1);
        gen_batch(5, 0, 1'b1, 1'b0);               // single run passes through
        gen_batch(70, 100, 1'b1, 1'b0);            // run table overflow

        rand_start = n_items;
        while (n_items - rand_start < RAND_ITEMS)
        begin
            if (n_items - rand_start > RAND_ITEMS * 4 / 5)
                calm = 1'b1;
            if ($urandom_range(0, 3) == 0)
                write_merge_enable(($urandom_range(0, 3) != 0));
            if ($urandom_range(0, 7) == 0)
                gen_batch($urandom_range(1, 30), 20, 1'b0, 1'b1);
            else
                gen_batch($urandom_range(1, 30), $urandom_range(5, 40), 1'b1, 1'b1);
        end

        while (beat_q.size() > 0 || merged_q.size() > 0 || s_tvalid)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
